>>> hdl/wtsp_pkg.sv
// ---------------------------------------------------------------------------
// wtsp_pkg
// Shared constants and types of the world to screen projection unit.
// ---------------------------------------------------------------------------
`default_nettype none

package wtsp_pkg;

   // Default field widths of world points and matrix coefficients.
   localparam int DEF_COORD_WIDTH = 24;
   localparam int DEF_COEFF_WIDTH = 16;

   // Fixed formats of the offsets, viewport size and results.
   localparam int OFFSET_WIDTH = 32;
   localparam int OFFSET_SHIFT = 8;
   localparam int DIM_WIDTH    = 14;
   localparam int SCALE_WIDTH  = 17;
   localparam int OUT_WIDTH    = 20;
   localparam int CSR_IDX_WIDTH = 3;

   // Quotient bits produced by the divider; larger quotients saturate.
   localparam int QUOT_BITS = 21;

   // Smallest visible depth sum (0.001 with 20 fraction bits, rounded up).
   localparam int DEPTH_MIN = 1049;

   localparam int OUT_MAX = 524287;
   localparam int OUT_MIN = -524288;

   localparam logic [DIM_WIDTH-1:0] WIDTH_RESET  = DIM_WIDTH'(1920);
   localparam logic [DIM_WIDTH-1:0] HEIGHT_RESET = DIM_WIDTH'(1080);

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      REG_HORIZ_COEFFS = 3'd0,
      REG_VERT_COEFFS  = 3'd1,
      REG_DEPTH_COEFFS = 3'd2,
      REG_HORIZ_OFFSET = 3'd3,
      REG_VERT_OFFSET  = 3'd4,
      REG_DEPTH_OFFSET = 3'd5,
      REG_SCREEN_WIDTH = 3'd6,
      REG_SCREEN_HEIGHT = 3'd7
   } csr_index_type;

endpackage

`default_nettype wire

>>> hdl/world_to_screen_projection_unit.sv
// ---------------------------------------------------------------------------
// world_to_screen_projection_unit
// Projects world points onto a viewport through a configured 3x4 matrix,
// perspective divide and viewport mapping, one point per cycle while not stalled.
// ---------------------------------------------------------------------------
//
//   Channel  Direction  Handshake          Contents
//   req_     in         valid / stall      world_x, world_y, world_z (Q16.8)
//   rsp_     out        valid / stall      visible, screen_x, screen_y (Q16.4)
//   csr_     in         write enable only  index, write data
//
// A point passes from acceptance to its result through four front stages
// (products, row sums, viewport scaling, sign split), 22 divider stages (an
// entry stage, then one per quotient bit) and the output register.
// One point is accepted per cycle while no result is held by rsp_stall.
// Reset clears all valid bits and loads the register defaults.
// While a result is held by rsp_stall the whole pipeline holds.
// ---------------------------------------------------------------------------
`default_nettype none

module world_to_screen_projection_unit import wtsp_pkg::*; #(
   parameter int COORD_WIDTH = DEF_COORD_WIDTH,
   parameter int COEFF_WIDTH = DEF_COEFF_WIDTH,
   localparam int CRW = 3 * COEFF_WIDTH,
   localparam int CSR_WIDTH = (CRW > OFFSET_WIDTH) ? CRW : OFFSET_WIDTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic signed [COORD_WIDTH-1:0] req_world_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_world_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_world_z,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_visible,
   output logic signed [OUT_WIDTH-1:0]        rsp_screen_x,
   output logic signed [OUT_WIDTH-1:0]        rsp_screen_y,
   input  wire logic                          csr_write_en,
   input  wire logic [CSR_IDX_WIDTH-1:0]      csr_index,
   input  wire logic [CSR_WIDTH-1:0]          csr_write_data
);

   localparam int PW = COORD_WIDTH + COEFF_WIDTH;
   localparam int OW = OFFSET_WIDTH + OFFSET_SHIFT;
   localparam int SW = ((PW > OW) ? PW : OW) + 2;
   localparam int DW = SW - 1;
   localparam int NW = SW + SCALE_WIDTH + 1;
   localparam int QW = QUOT_BITS + 2;
   localparam int TW = QUOT_BITS + 3;

   logic [CRW-1:0]                 horiz_coeffs_ff, vert_coeffs_ff, depth_coeffs_ff;
   logic signed [OFFSET_WIDTH-1:0] horiz_offset_ff, vert_offset_ff, depth_offset_ff;
   logic [DIM_WIDTH-1:0]           screen_width_ff, screen_height_ff;

   logic          enable;
   logic          fr_valid, fr_visible, fr_x_neg, fr_x_ovf, fr_y_neg, fr_y_ovf;
   logic [DW-1:0] fr_depth;
   logic [NW-1:0] fr_x_mag, fr_y_mag;

   logic                 dx_valid, dy_valid, dx_rem_nz, dy_rem_nz;
   logic [QUOT_BITS-1:0] dx_quot, dy_quot;
   logic [2:0]           dx_side;
   logic [1:0]           dy_side;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_visible_ff, rsp_visible_in;
   logic signed [OUT_WIDTH-1:0] rsp_screen_x_ff, rsp_screen_x_in;
   logic signed [OUT_WIDTH-1:0] rsp_screen_y_ff, rsp_screen_y_in;
   logic signed [TW-1:0]        base_x, base_y;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         horiz_coeffs_ff  <= '0;
         vert_coeffs_ff   <= '0;
         depth_coeffs_ff  <= '0;
         horiz_offset_ff  <= '0;
         vert_offset_ff   <= '0;
         depth_offset_ff  <= '0;
         screen_width_ff  <= WIDTH_RESET;
         screen_height_ff <= HEIGHT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_HORIZ_COEFFS:  horiz_coeffs_ff  <= csr_write_data[CRW-1:0];
            REG_VERT_COEFFS:   vert_coeffs_ff   <= csr_write_data[CRW-1:0];
            REG_DEPTH_COEFFS:  depth_coeffs_ff  <= csr_write_data[CRW-1:0];
            REG_HORIZ_OFFSET:  horiz_offset_ff  <= csr_write_data[OFFSET_WIDTH-1:0];
            REG_VERT_OFFSET:   vert_offset_ff   <= csr_write_data[OFFSET_WIDTH-1:0];
            REG_DEPTH_OFFSET:  depth_offset_ff  <= csr_write_data[OFFSET_WIDTH-1:0];
            REG_SCREEN_WIDTH:  screen_width_ff  <= csr_write_data[DIM_WIDTH-1:0];
            REG_SCREEN_HEIGHT: screen_height_ff <= csr_write_data[DIM_WIDTH-1:0];
         endcase
      end
   end

   // The pipeline advances unless a finished result is being held.
   assign enable    = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !enable;

   wtsp_front #(
      .COORD_WIDTH(COORD_WIDTH),
      .COEFF_WIDTH(COEFF_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .enable       (enable),
      .in_valid     (req_valid),
      .world_x      (req_world_x),
      .world_y      (req_world_y),
      .world_z      (req_world_z),
      .horiz_coeffs (horiz_coeffs_ff),
      .vert_coeffs  (vert_coeffs_ff),
      .depth_coeffs (depth_coeffs_ff),
      .horiz_offset (horiz_offset_ff),
      .vert_offset  (vert_offset_ff),
      .depth_offset (depth_offset_ff),
      .screen_width (screen_width_ff),
      .screen_height(screen_height_ff),
      .out_valid    (fr_valid),
      .out_visible  (fr_visible),
      .out_depth    (fr_depth),
      .out_x_mag    (fr_x_mag),
      .out_x_neg    (fr_x_neg),
      .out_x_ovf    (fr_x_ovf),
      .out_y_mag    (fr_y_mag),
      .out_y_neg    (fr_y_neg),
      .out_y_ovf    (fr_y_ovf)
   );

   // Horizontal divider; it also carries the visibility flag.
   wtsp_divider #(.NW(NW), .DW(DW), .SBW(3)) u_div_x (
      .clock      (clock),
      .reset      (reset),
      .enable     (enable),
      .in_valid   (fr_valid),
      .in_dividend(fr_x_mag),
      .in_divisor (fr_depth),
      .in_side    ({fr_visible, fr_x_neg, fr_x_ovf}),
      .out_valid  (dx_valid),
      .out_quot   (dx_quot),
      .out_rem_nz (dx_rem_nz),
      .out_side   (dx_side)
   );

   wtsp_divider #(.NW(NW), .DW(DW), .SBW(2)) u_div_y (
      .clock      (clock),
      .reset      (reset),
      .enable     (enable),
      .in_valid   (fr_valid),
      .in_dividend(fr_y_mag),
      .in_divisor (fr_depth),
      .in_side    ({fr_y_neg, fr_y_ovf}),
      .out_valid  (dy_valid),
      .out_quot   (dy_quot),
      .out_rem_nz (dy_rem_nz),
      .out_side   (dy_side)
   );

   // Floor the quotient, add the viewport center and saturate.
   function automatic logic signed [OUT_WIDTH-1:0] place(
      input logic signed [TW-1:0]  base,
      input logic [QUOT_BITS-1:0]  quot,
      input logic                  rem_nz,
      input logic                  neg,
      input logic                  ovf
   );
      logic [QW-1:0]        mag;
      logic signed [QW-1:0] q;
      logic signed [TW-1:0] total;
      mag   = QW'(quot) + QW'(neg && rem_nz);
      q     = neg ? $signed(-mag) : $signed(mag);
      total = base + TW'(q);
      if (ovf) begin
         place = neg ? OUT_WIDTH'(OUT_MIN) : OUT_WIDTH'(OUT_MAX);
      end else if (total > $signed(TW'(OUT_MAX))) begin
         place = OUT_WIDTH'(OUT_MAX);
      end else if (total < $signed(TW'(OUT_MIN))) begin
         place = OUT_WIDTH'(OUT_MIN);
      end else begin
         place = total[OUT_WIDTH-1:0];
      end
   endfunction

   always_comb begin
      base_x = $signed(TW'({screen_width_ff, 3'b000})) + $signed(TW'(8));
      base_y = $signed(TW'({screen_height_ff, 3'b000})) - $signed(TW'(8));
      rsp_visible_in  = dx_side[2];
      rsp_screen_x_in = '0;
      rsp_screen_y_in = '0;
      if (dx_side[2]) begin
         rsp_screen_x_in = place(base_x, dx_quot, dx_rem_nz, dx_side[1], dx_side[0]);
         rsp_screen_y_in = place(base_y, dy_quot, dy_rem_nz, dy_side[1], dy_side[0]);
      end
      rsp_valid_in = enable ? (dx_valid && dy_valid) : rsp_valid_ff;
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rsp_visible_ff  <= rsp_visible_in;
         rsp_screen_x_ff <= rsp_screen_x_in;
         rsp_screen_y_ff <= rsp_screen_y_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_visible  = rsp_visible_ff;
   assign rsp_screen_x = rsp_screen_x_ff;
   assign rsp_screen_y = rsp_screen_y_ff;

endmodule

`default_nettype wire

>>> hdl/wtsp_front.sv
// ---------------------------------------------------------------------------
// wtsp_front
// Front pipeline: three dot products, viewport scaling, visibility test and
// sign/magnitude split ahead of the dividers. Four register stages.
// ---------------------------------------------------------------------------
`default_nettype none

module wtsp_front import wtsp_pkg::*; #(
   parameter int COORD_WIDTH = DEF_COORD_WIDTH,
   parameter int COEFF_WIDTH = DEF_COEFF_WIDTH,
   localparam int PW = COORD_WIDTH + COEFF_WIDTH,
   localparam int OW = OFFSET_WIDTH + OFFSET_SHIFT,
   localparam int SW = ((PW > OW) ? PW : OW) + 2,
   localparam int DW = SW - 1,
   localparam int NW = SW + SCALE_WIDTH + 1
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          enable,
   input  wire logic                          in_valid,
   input  wire logic signed [COORD_WIDTH-1:0] world_x,
   input  wire logic signed [COORD_WIDTH-1:0] world_y,
   input  wire logic signed [COORD_WIDTH-1:0] world_z,
   input  wire logic [3*COEFF_WIDTH-1:0]      horiz_coeffs,
   input  wire logic [3*COEFF_WIDTH-1:0]      vert_coeffs,
   input  wire logic [3*COEFF_WIDTH-1:0]      depth_coeffs,
   input  wire logic signed [OFFSET_WIDTH-1:0] horiz_offset,
   input  wire logic signed [OFFSET_WIDTH-1:0] vert_offset,
   input  wire logic signed [OFFSET_WIDTH-1:0] depth_offset,
   input  wire logic [DIM_WIDTH-1:0]          screen_width,
   input  wire logic [DIM_WIDTH-1:0]          screen_height,
   output logic                               out_valid,
   output logic                               out_visible,
   output logic [DW-1:0]                      out_depth,
   output logic [NW-1:0]                      out_x_mag,
   output logic                               out_x_neg,
   output logic                               out_x_ovf,
   output logic [NW-1:0]                      out_y_mag,
   output logic                               out_y_neg,
   output logic                               out_y_ovf
);

   logic                 s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic signed [PW-1:0] prod_ff [3][3];
   logic signed [PW-1:0] prod_in [3][3];
   logic signed [SW-1:0] sum_ff [3];
   logic signed [SW-1:0] sum_in [3];
   logic signed [NW-1:0] ph_ff, pv_ff, ph_in, pv_in;
   logic signed [SW-1:0] d3_ff;
   logic                 vis3_ff, vis3_in;
   logic [NW-1:0]        xmag_in, ymag_in;
   logic                 xneg_in, yneg_in, xovf_in, yovf_in;
   logic [NW-QUOT_BITS-1:0] xhi, yhi;
   logic [DW-1:0]        d4_ff;
   logic [NW-1:0]        xmag_ff, ymag_ff;
   logic                 xneg_ff, yneg_ff, xovf_ff, yovf_ff, vis4_ff;
   logic [3*COEFF_WIDTH-1:0] rows [3];
   logic signed [OFFSET_WIDTH-1:0] offs [3];
   logic signed [COORD_WIDTH-1:0]  pt [3];

   assign rows[0] = horiz_coeffs;
   assign rows[1] = vert_coeffs;
   assign rows[2] = depth_coeffs;
   assign offs[0] = horiz_offset;
   assign offs[1] = vert_offset;
   assign offs[2] = depth_offset;
   assign pt[0]   = world_x;
   assign pt[1]   = world_y;
   assign pt[2]   = world_z;

   // Stage 1: nine coefficient by coordinate products.
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) begin
            prod_in[r][k] = PW'($signed(rows[r][k*COEFF_WIDTH +: COEFF_WIDTH]))
                          * PW'(pt[k]);
         end
      end
   end

   // Stage 2: row sums with the offsets aligned to 20 fraction bits.
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         sum_in[r] = SW'(prod_ff[r][0]) + SW'(prod_ff[r][1]) + SW'(prod_ff[r][2])
                   + (SW'(offs[r]) <<< OFFSET_SHIFT);
      end
   end

   // Stage 3: scale by the viewport size and test the depth.
   always_comb begin
      ph_in   = NW'(sum_ff[0]) * NW'($signed({1'b0, screen_width, 3'b000}));
      pv_in   = NW'(sum_ff[1]) * NW'($signed({1'b0, screen_height, 3'b000}));
      vis3_in = sum_ff[2] >= $signed(SW'(DEPTH_MIN));
   end

   // Stage 4: sign and magnitude; flag quotients too large for the divider.
   // The vertical numerator is negated, so its sign flips.
   always_comb begin
      xneg_in = ph_ff[NW-1];
      xmag_in = ph_ff[NW-1] ? NW'(-ph_ff) : NW'(ph_ff);
      yneg_in = !pv_ff[NW-1] && (pv_ff != '0);
      ymag_in = pv_ff[NW-1] ? NW'(-pv_ff) : NW'(pv_ff);
      xhi     = xmag_in[NW-1:QUOT_BITS];
      yhi     = ymag_in[NW-1:QUOT_BITS];
      xovf_in = NW'(xhi) >= NW'(d3_ff[DW-1:0]);
      yovf_in = NW'(yhi) >= NW'(d3_ff[DW-1:0]);
   end

   // Valid bits of the four stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (enable) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   // Payload registers of the four stages.
   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff <= prod_in;
         sum_ff  <= sum_in;
         ph_ff   <= ph_in;
         pv_ff   <= pv_in;
         d3_ff   <= sum_ff[2];
         vis3_ff <= vis3_in;
         xmag_ff <= xmag_in;
         ymag_ff <= ymag_in;
         xneg_ff <= xneg_in;
         yneg_ff <= yneg_in;
         xovf_ff <= xovf_in;
         yovf_ff <= yovf_in;
         d4_ff   <= d3_ff[DW-1:0];
         vis4_ff <= vis3_ff;
      end
   end

   assign out_valid   = s4_valid_ff;
   assign out_visible = vis4_ff;
   assign out_depth   = d4_ff;
   assign out_x_mag   = xmag_ff;
   assign out_x_neg   = xneg_ff;
   assign out_x_ovf   = xovf_ff;
   assign out_y_mag   = ymag_ff;
   assign out_y_neg   = yneg_ff;
   assign out_y_ovf   = yovf_ff;

endmodule

`default_nettype wire

>>> hdl/wtsp_divider.sv
// ---------------------------------------------------------------------------
// wtsp_divider
// Pipelined restoring divider: an entry stage, then one quotient bit per
// stage, with side bits and a valid bit carried along with each operand pair.
// ---------------------------------------------------------------------------
`default_nettype none

module wtsp_divider import wtsp_pkg::*; #(
   parameter int NW  = 60,
   parameter int DW  = 42,
   parameter int SBW = 1
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 enable,
   input  wire logic                 in_valid,
   input  wire logic [NW-1:0]        in_dividend,
   input  wire logic [DW-1:0]        in_divisor,
   input  wire logic [SBW-1:0]       in_side,
   output logic                      out_valid,
   output logic [QUOT_BITS-1:0]      out_quot,
   output logic                      out_rem_nz,
   output logic [SBW-1:0]            out_side
);

   logic                 valid_ff [QUOT_BITS+1];
   logic [DW-1:0]        rem_ff   [QUOT_BITS+1];
   logic [QUOT_BITS-1:0] low_ff   [QUOT_BITS+1];
   logic [QUOT_BITS-1:0] quot_ff  [QUOT_BITS+1];
   logic [DW-1:0]        div_ff   [QUOT_BITS+1];
   logic [SBW-1:0]       side_ff  [QUOT_BITS+1];

   // Entry stage: the high dividend bits form the first partial remainder.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (enable) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0]  <= DW'(in_dividend[NW-1:QUOT_BITS]);
         low_ff[0]  <= in_dividend[QUOT_BITS-1:0];
         quot_ff[0] <= '0;
         div_ff[0]  <= in_divisor;
         side_ff[0] <= in_side;
      end
   end

   // One compare and subtract per stage.
   for (genvar k = 1; k <= QUOT_BITS; k++) begin : g_stage
      logic [DW:0]   trial;
      logic          take;
      logic [DW-1:0] rem_in;

      always_comb begin
         trial  = {rem_ff[k-1], low_ff[k-1][QUOT_BITS-1]};
         take   = trial >= {1'b0, div_ff[k-1]};
         rem_in = take ? DW'(trial - {1'b0, div_ff[k-1]}) : trial[DW-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (enable) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k]  <= rem_in;
            low_ff[k]  <= {low_ff[k-1][QUOT_BITS-2:0], 1'b0};
            quot_ff[k] <= {quot_ff[k-1][QUOT_BITS-2:0], take};
            div_ff[k]  <= div_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign out_valid  = valid_ff[QUOT_BITS];
   assign out_quot   = quot_ff[QUOT_BITS];
   assign out_rem_nz = rem_ff[QUOT_BITS] != '0;
   assign out_side   = side_ff[QUOT_BITS];

endmodule

`default_nettype wire

>>> hdl/wtsp_checker.sv
// ---------------------------------------------------------------------------
// wtsp_checker
// Port-level checks of the projection unit, bound to its top level.
// ---------------------------------------------------------------------------
`default_nettype none

module wtsp_checker import wtsp_pkg::*; (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_stall,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_stall,
   input wire logic                 rsp_visible,
   input wire logic [OUT_WIDTH-1:0] rsp_screen_x,
   input wire logic [OUT_WIDTH-1:0] rsp_screen_y
);

   // A point behind the near limit yields zero coordinates.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_visible |-> rsp_screen_x == '0 && rsp_screen_y == '0)
      else $error("hidden point with nonzero coordinates");

   // No result comes out in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Input is stalled only while a result is held.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a held result");

   // A held result stays unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_screen_x)
         && $stable(rsp_screen_y) && $stable(rsp_visible))
      else $error("held result changed");

endmodule

bind world_to_screen_projection_unit wtsp_checker u_wtsp_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_visible (rsp_visible),
   .rsp_screen_x(rsp_screen_x),
   .rsp_screen_y(rsp_screen_y)
);

`default_nettype wire
